### hdl/fpps_pkg.sv
`default_nettype none

package fpps_pkg;

	// Fraction bits of the Q-scaled gains.
	localparam int FRAC_BITS = 14;

	localparam int DATA_W = 32;
	localparam int DRIVE_W = 16;

	// Six 32-bit registers at byte addresses 0x00 to 0x14.
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W = REG_IDX_W + 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KP     = 3'd0,
		REG_KI     = 3'd1,
		REG_KD     = 3'd2,
		REG_TARGET = 3'd3,
		REG_FLOOR  = 3'd4,
		REG_CEIL   = 3'd5
	} reg_idx_t;

	localparam logic signed [DATA_W-1:0] KP_RST     = 32'sd500;
	localparam logic signed [DATA_W-1:0] KI_RST     = 32'sd200;
	localparam logic signed [DATA_W-1:0] KD_RST     = 32'sd200;
	localparam logic signed [DATA_W-1:0] TARGET_RST = 32'sd3000;
	localparam logic [DRIVE_W-1:0]       FLOOR_RST  = 16'h0000;
	localparam logic [DRIVE_W-1:0]       CEIL_RST   = 16'h1000;

	typedef struct packed {
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kd;
		logic signed [DATA_W-1:0] target;
		logic [DRIVE_W-1:0]       floor_val;
		logic [DRIVE_W-1:0]       ceil_val;
	} cfg_t;

	// Terms that depend only on the sample, handed to the feedback stage.
	typedef struct packed {
		logic signed [DATA_W-1:0] p_term;
		logic signed [DATA_W-1:0] i_inc;
	} prod_t;

endpackage

`default_nettype wire

### hdl/fpps_regs.sv
`default_nettype none

module fpps_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fpps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output fpps_pkg::cfg_t                  cfg
);
	import fpps_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp        <= KP_RST;
			cfg_q.ki        <= KI_RST;
			cfg_q.kd        <= KD_RST;
			cfg_q.target    <= TARGET_RST;
			cfg_q.floor_val <= FLOOR_RST;
			cfg_q.ceil_val  <= CEIL_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_KP:     cfg_q.kp        <= pwdata;
				REG_KI:     cfg_q.ki        <= pwdata;
				REG_KD:     cfg_q.kd        <= pwdata;
				REG_TARGET: cfg_q.target    <= pwdata;
				REG_FLOOR:  cfg_q.floor_val <= pwdata[DRIVE_W-1:0];
				REG_CEIL:   cfg_q.ceil_val  <= pwdata[DRIVE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP:     prdata = cfg_q.kp;
			REG_KI:     prdata = cfg_q.ki;
			REG_KD:     prdata = cfg_q.kd;
			REG_TARGET: prdata = cfg_q.target;
			REG_FLOOR:  prdata = {{(32-DRIVE_W){1'b0}}, cfg_q.floor_val};
			REG_CEIL:   prdata = {{(32-DRIVE_W){1'b0}}, cfg_q.ceil_val};
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/fpps_front.sv
`default_nettype none

module fpps_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fpps_pkg::cfg_t              cfg,
	input  wire logic                        sample_valid,
	output logic                             sample_ready,
	input  wire logic signed [fpps_pkg::DATA_W-1:0] measured,
	output logic                             prod_valid,
	input  wire logic                        prod_ready,
	output fpps_pkg::prod_t                  prod
);
	import fpps_pkg::*;

	logic                     v_s1;
	logic signed [DATA_W-1:0] err_s1;
	logic                     v_s2;
	prod_t                    prod_s2;

	logic                     en_s1;
	logic                     en_s2;
	logic                     adv_s2;
	logic signed [DATA_W-1:0] ki_err;
	prod_t                    prod_next;

	// A stage loads when it is empty or its content moves on this cycle.
	assign en_s2        = !v_s2 || prod_ready;
	assign adv_s2       = v_s1 && en_s2;
	assign en_s1        = !v_s1 || adv_s2;
	assign sample_ready = en_s1;

	// Products wrap to 32 bits; the integral increment is shifted arithmetically.
	assign ki_err           = cfg.ki * err_s1;
	assign prod_next.p_term = cfg.kp * err_s1;
	assign prod_next.i_inc  = ki_err >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= sample_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			err_s1 <= measured - cfg.target;
		end
		if (adv_s2) begin
			prod_s2 <= prod_next;
		end
	end

	assign prod_valid = v_s2;
	assign prod       = prod_s2;

endmodule

`default_nettype wire

### hdl/fpps_core.sv
`default_nettype none

module fpps_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire fpps_pkg::cfg_t               cfg,
	input  wire logic                         prod_valid,
	output logic                              prod_ready,
	input  wire fpps_pkg::prod_t              prod,
	output logic                              drive_valid,
	input  wire logic                         drive_ready,
	output logic [fpps_pkg::DRIVE_W-1:0]      drive
);
	import fpps_pkg::*;

	logic                     drive_valid_q;
	logic signed [DATA_W-1:0] integral_q;
	logic [DRIVE_W-1:0]       drive_now_q;
	logic [DRIVE_W-1:0]       drive_before_q;

	logic                            step;
	logic signed [DATA_W-1:0]        integral_next;
	logic signed [DRIVE_W:0]         diff;
	logic signed [DATA_W+DRIVE_W:0]  d_full;
	logic signed [DATA_W-1:0]        sum;
	logic signed [DATA_W-1:0]        val;
	logic signed [DATA_W:0]          val_x;
	logic signed [DATA_W:0]          floor_x;
	logic signed [DATA_W:0]          ceil_x;
	logic signed [DATA_W:0]          clamp_lo;
	logic signed [DATA_W:0]          clamp_hi;
	logic [DRIVE_W-1:0]              drive_next;

	// The drive register doubles as the output register.
	assign prod_ready = !drive_valid_q || drive_ready;
	assign step       = prod_valid && prod_ready;

	assign integral_next = integral_q + prod.i_inc;
	assign diff          = $signed({1'b0, drive_now_q}) - $signed({1'b0, drive_before_q});
	assign d_full        = cfg.kd * diff;
	assign sum           = prod.p_term + integral_next + d_full[DATA_W-1:0];
	assign val           = sum >>> FRAC_BITS;

	// Signed compare of the shifted sum against the unsigned limits.
	assign val_x    = {val[DATA_W-1], val};
	assign floor_x  = $signed({{(DATA_W+1-DRIVE_W){1'b0}}, cfg.floor_val});
	assign ceil_x   = $signed({{(DATA_W+1-DRIVE_W){1'b0}}, cfg.ceil_val});
	assign clamp_lo = (val_x < floor_x) ? floor_x : val_x;
	assign clamp_hi = (ceil_x < clamp_lo) ? ceil_x : clamp_lo;

	assign drive_next = cfg.ceil_val - clamp_hi[DRIVE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q  <= 1'b0;
			integral_q     <= '0;
			drive_now_q    <= '0;
			drive_before_q <= '0;
		end else begin
			if (prod_ready) begin
				drive_valid_q <= prod_valid;
			end
			if (step) begin
				integral_q     <= integral_next;
				drive_before_q <= drive_now_q;
				drive_now_q    <= drive_next;
			end
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_now_q;

endmodule

`default_nettype wire

### hdl/fixed_point_pid_step_top.sv
// Fixed-point PID step: one measured speed sample in, one drive value out.
// The sample channel (sample_valid, sample_ready, measured) takes one beat per
// sample; the drive channel (drive_valid, drive_ready, drive) returns one beat
// per sample, in order. Gains, setpoint, floor and ceiling sit behind an
// APB-style port at byte addresses 0x00 to 0x14; the user must write them
// only while idle, which the block does not enforce. A sample passes through
// the error register, product register and drive register. Throughput: one
// beat per cycle while drive_ready stays high. The figure is set by the
// feedback stage, where the derivative multiply of the last two drive values,
// the integral add, the final sum and the clamp all close in the same cycle.
// Reset clears the integral, both drive history values and all pipeline
// valid flags, and loads the configuration reset values.
// When the receiver stalls, the finished drive beat holds in the output
// register, and the two stages in front keep filling until they are full,
// after which sample_ready drops.
`default_nettype none

module fixed_point_pid_step_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fpps_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	input  wire logic                              sample_valid,
	output logic                                   sample_ready,
	input  wire logic signed [fpps_pkg::DATA_W-1:0] measured,
	output logic                                   drive_valid,
	input  wire logic                              drive_ready,
	output logic [fpps_pkg::DRIVE_W-1:0]           drive
);
	import fpps_pkg::*;

	cfg_t  cfg;
	prod_t prod;
	logic  prod_valid;
	logic  prod_ready;

	// Configuration registers and their read mux.
	fpps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Error and the two sample-only products (P term, integral increment).
	fpps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.measured     (measured),
		.prod_valid   (prod_valid),
		.prod_ready   (prod_ready),
		.prod         (prod)
	);

	// Feedback stage: integral, derivative on drive history, clamp, inversion.
	fpps_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.prod_valid  (prod_valid),
		.prod_ready  (prod_ready),
		.prod        (prod),
		.drive_valid (drive_valid),
		.drive_ready (drive_ready),
		.drive       (drive)
	);

`ifndef SYNTH
	// A beat that enters the feedback stage shows up as a drive beat next cycle.
	a_step_gives_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(prod_valid && prod_ready) |=> drive_valid)
		else $error("feedback stage step produced no drive beat");

	// An empty output register never blocks the feedback stage.
	a_core_not_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!drive_valid |-> prod_ready)
		else $error("feedback stage stalled with empty output register");

	// With the product stage empty the block must take a sample.
	a_front_open: assert property (@(posedge clk) disable iff (!arst_n)
		!prod_valid |-> sample_ready)
		else $error("sample_ready low with empty product stage");

	// A taken drive beat with nothing behind it leaves the output empty.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_valid && drive_ready && !prod_valid) |=> !drive_valid)
		else $error("drive beat repeated");
`endif

endmodule

`default_nettype wire
